FILE: design/lrukv_pkg.sv
`timescale 1ns / 1ps

package lrukv_pkg;

    localparam int DEFAULT_ENTRIES  = 16;
    localparam int DEFAULT_KEY_BITS = 16;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
    localparam logic [VALUE_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } t_action;

endpackage

FILE: design/lru_key_value_cache_unit.sv
`timescale 1ns / 1ps

// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle unless the result side stalls; the tag compare over all
// entries and the age update for the hit, victim or free entry complete between the two registers.
// Reset (i_rst_n low, synchronous): all entries invalid, ages and fill count zero,
// capacity 16, both pipeline registers empty. Key and data stores are not cleared.
module lru_key_value_cache_unit #(
    parameter int ENTRIES  = lrukv_pkg::DEFAULT_ENTRIES,
    parameter int KEY_BITS = lrukv_pkg::DEFAULT_KEY_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lrukv_pkg::CAP_W-1:0]      i_cfg_wr_data,   // capacity
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lrukv_pkg::IN_DATA_W-1:0]  s_axis_tdata,    // key[15:0], value[47:16]
    input  logic                            s_axis_tuser,    // action
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lrukv_pkg::OUT_DATA_W-1:0] m_axis_tdata,    // read_value[31:0], evicted_key[47:32]
    output logic [lrukv_pkg::OUT_USER_W-1:0] m_axis_tuser     // hit[0], evicted[1]
);
    import lrukv_pkg::*;

    localparam int AGE_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? '1 : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

    // capacity
    logic [CAP_W-1:0] r_cap;

    // input register
    logic               r_in_valid;
    t_action            r_in_action;
    logic [KEY_W-1:0]   r_in_key;
    logic [VALUE_W-1:0] r_in_value;

    // result register
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_evicted;
    logic [VALUE_W-1:0] r_out_read_value;
    logic [KEY_W-1:0]   r_out_evicted_key;

    // entry store
    logic [ENTRIES-1:0] r_valid;
    logic [KEY_W-1:0]   r_key  [ENTRIES];
    logic [VALUE_W-1:0] r_data [ENTRIES];
    logic [AGE_W-1:0]   r_age  [ENTRIES];
    logic [FILL_W-1:0]  r_fill;

    logic               advance;
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] hit_oh;
    logic [ENTRIES-1:0] free_oh;
    logic [ENTRIES-1:0] victim_oh;
    logic [ENTRIES-1:0] tgt_oh;
    logic               hit;
    logic               is_put;
    logic               must_evict;
    logic               do_evict;
    logic               do_fill;
    logic               do_update;
    logic [VALUE_W-1:0] hit_data;
    logic [AGE_W-1:0]   hit_age;
    logic [KEY_W-1:0]   ev_key;
    logic [FILL_W-1:0]  fill_m1;
    logic [FILL_W-1:0]  thresh;
    logic [CMP_W-1:0]   eff_cap;

    logic               n_out_hit;
    logic               n_out_evicted;
    logic [VALUE_W-1:0] n_out_read_value;
    logic [KEY_W-1:0]   n_out_evicted_key;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_comb begin
        hit_data = '0;
        hit_age  = '0;
        ev_key   = '0;
        fill_m1  = r_fill - FILL_W'(1);
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]     = r_valid[i] && (r_key[i] == r_in_key);
            victim_oh[i] = r_valid[i] && (FILL_W'(r_age[i]) == fill_m1);
        end
        hit_oh  = match & (~match + ENTRIES'(1));
        free_oh = ~r_valid & (r_valid + ENTRIES'(1));
        for (int i = 0; i < ENTRIES; i++) begin
            if (hit_oh[i]) begin
                hit_data = hit_data | r_data[i];
                hit_age  = hit_age | r_age[i];
            end
            if (victim_oh[i]) begin
                ev_key = ev_key | r_key[i];
            end
        end
        hit    = |match;
        is_put = (r_in_action == ACT_PUT);

        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
        must_evict = CMP_W'(r_fill) >= eff_cap;
        do_evict   = is_put && !hit && must_evict;
        do_fill    = is_put && !hit && !must_evict;
        do_update  = hit || do_evict || do_fill;

        if (hit) begin
            tgt_oh = hit_oh;
            thresh = FILL_W'(hit_age);
        end else if (do_evict) begin
            tgt_oh = victim_oh;
            thresh = fill_m1;
        end else begin
            tgt_oh = free_oh;
            thresh = r_fill;
        end

        n_out_hit         = hit;
        n_out_evicted     = do_evict;
        n_out_evicted_key = do_evict ? ev_key : '0;
        if (is_put) begin
            n_out_read_value = '0;
        end else if (hit) begin
            n_out_read_value = hit_data;
        end else begin
            n_out_read_value = MISS_VALUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_fill      <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance && do_update) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tgt_oh[i]) begin
                        r_age[i] <= '0;
                    end else if (r_valid[i] && (FILL_W'(r_age[i]) < thresh)) begin
                        r_age[i] <= r_age[i] + AGE_W'(1);
                    end
                end
                if (do_fill) begin
                    r_valid <= r_valid | tgt_oh;
                    r_fill  <= r_fill + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= t_action'(s_axis_tuser);
            r_in_key    <= s_axis_tdata[KEY_W-1:0] & KEY_MASK;
            r_in_value  <= s_axis_tdata[KEY_W +: VALUE_W];
        end
        if (advance) begin
            r_out_hit         <= n_out_hit;
            r_out_evicted     <= n_out_evicted;
            r_out_read_value  <= n_out_read_value;
            r_out_evicted_key <= n_out_evicted_key;
            for (int i = 0; i < ENTRIES; i++) begin
                if (tgt_oh[i] && is_put) begin
                    r_data[i] <= r_in_value;
                end
                if (tgt_oh[i] && (do_evict || do_fill)) begin
                    r_key[i] <= r_in_key;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_evicted_key, r_out_read_value};
    assign m_axis_tuser  = {r_out_evicted, r_out_hit};

    a_fill_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_fill))
        else $error("fill count differs from number of valid entries");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= ENTRIES)
        else $error("fill count above entry count");

    a_no_duplicate_keys: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(match))
        else $error("key present in more than one entry");

    a_single_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && do_evict) |-> $onehot(victim_oh))
        else $error("eviction without a unique least recent entry");

    a_fill_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && do_fill) |-> $onehot(free_oh))
        else $error("fill without a free entry");

endmodule

FILE: sim/lru_key_value_cache_checker.sv
`timescale 1ns / 1ps

module lru_key_value_cache_checker #(
    parameter int ENTRIES  = lrukv_pkg::DEFAULT_ENTRIES,
    parameter int KEY_BITS = lrukv_pkg::DEFAULT_KEY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lrukv_pkg::CAP_W-1:0]      i_cfg_wr_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [lrukv_pkg::IN_DATA_W-1:0]  i_s_tdata,    // key[15:0], value[47:16]
    input  logic                             i_s_tuser,    // action
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [lrukv_pkg::OUT_DATA_W-1:0] i_m_tdata,    // read_value[31:0], evicted_key[47:32]
    input  logic [lrukv_pkg::OUT_USER_W-1:0] i_m_tuser,    // hit[0], evicted[1]
    output int                               o_pending,
    output int                               o_fail_count
);
    import lrukv_pkg::*;

    typedef struct packed {
        logic               hit;
        logic [VALUE_W-1:0] read_value;
        logic               evicted;
        logic [KEY_W-1:0]   evicted_key;
    } t_cache_result;

    logic [CAP_W-1:0]   capacity;
    logic               slot_valid [ENTRIES];
    logic [KEY_W-1:0]   slot_key   [ENTRIES];
    logic [VALUE_W-1:0] slot_value [ENTRIES];
    int                 slot_age   [ENTRIES];
    int                 fill_count;

    t_cache_result      pending_results [$];
    t_cache_result      expected;
    t_cache_result      actual;

    // Entries more recent than idx age by one; idx becomes the newest.
    function automatic void make_newest(input int idx);
        int old_age;
        old_age = slot_age[idx];
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && i != idx && slot_age[i] < old_age) begin
                slot_age[i]++;
            end
        end
        slot_age[idx] = 0;
    endfunction

    function automatic t_cache_result cache_access(input t_action act,
                                                   input logic [KEY_W-1:0] raw_key,
                                                   input logic [VALUE_W-1:0] val);
        t_cache_result    r;
        logic [KEY_W-1:0] key;
        int               found;
        int               victim;
        int               free_slot;
        int               eff_cap;
        r       = '0;
        key     = raw_key & KEY_W'((64'd1 << KEY_BITS) - 1);
        found   = -1;
        victim  = -1;
        free_slot = -1;
        eff_cap = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : int'(capacity));
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && slot_key[i] == key) begin
                found = i;
            end
        end
        if (act == ACT_GET) begin
            if (found >= 0) begin
                r.hit        = 1'b1;
                r.read_value = slot_value[found];
                make_newest(found);
            end else begin
                r.read_value = MISS_VALUE;
            end
        end else if (found >= 0) begin
            r.hit             = 1'b1;
            slot_value[found] = val;
            make_newest(found);
        end else begin
            if (fill_count >= eff_cap) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (slot_valid[i] && (victim < 0 || slot_age[i] > slot_age[victim])) begin
                        victim = i;
                    end
                end
            end
            if (victim >= 0) begin
                r.evicted          = 1'b1;
                r.evicted_key      = slot_key[victim];
                slot_key[victim]   = key;
                slot_value[victim] = val;
                make_newest(victim);
            end else begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (free_slot < 0 && !slot_valid[i]) begin
                        free_slot = i;
                    end
                end
                if (free_slot >= 0) begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_valid[i]) begin
                            slot_age[i]++;
                        end
                    end
                    slot_valid[free_slot] = 1'b1;
                    slot_key[free_slot]   = key;
                    slot_value[free_slot] = val;
                    slot_age[free_slot]   = 0;
                    fill_count++;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity   = CAP_RESET;
            fill_count = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_value[i] = '0;
                slot_age[i]   = 0;
            end
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                actual.hit         = i_m_tuser[0];
                actual.evicted     = i_m_tuser[1];
                actual.read_value  = i_m_tdata[31:0];
                actual.evicted_key = i_m_tdata[47:32];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, actual);
                    o_fail_count++;
                end else begin
                    expected = pending_results.pop_front();
                    if (actual.hit !== expected.hit) begin
                        $display("%0t: hit expected %0b got %0b",
                                 $time, expected.hit, actual.hit);
                        o_fail_count++;
                    end
                    if (actual.read_value !== expected.read_value) begin
                        $display("%0t: read_value expected %h got %h",
                                 $time, expected.read_value, actual.read_value);
                        o_fail_count++;
                    end
                    if (actual.evicted !== expected.evicted) begin
                        $display("%0t: evicted expected %0b got %0b",
                                 $time, expected.evicted, actual.evicted);
                        o_fail_count++;
                    end
                    if (actual.evicted_key !== expected.evicted_key) begin
                        $display("%0t: evicted_key expected %h got %h",
                                 $time, expected.evicted_key, actual.evicted_key);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_results.push_back(cache_access(t_action'(i_s_tuser),
                                                       i_s_tdata[15:0], i_s_tdata[47:16]));
            end
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
        end
        o_pending = pending_results.size();
    end

endmodule

FILE: sim/tb_lru_key_value_cache_unit.sv
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;
    import lrukv_pkg::*;

    localparam int NUM_SEGMENTS    = 8;
    localparam int SEGMENT_ITEMS   = 200;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wr_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = ACT_GET;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int pending_count;
    int fail_count;
    int src_idle_pct  = 10;
    int sink_idle_pct = 75;
    bit hold_off_req  = 1'b0;

    logic [CAP_W-1:0] segment_caps [NUM_SEGMENTS] = '{5'd1, 5'd31, 5'd5, 5'd16,
                                                      5'd0, 5'd2, 5'd12, 5'd3};
    logic [KEY_W-1:0] key_pool [32];

    lru_key_value_cache_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lru_key_value_cache_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_pending     (pending_count),
        .o_fail_count  (fail_count)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // tvalid stays high after acceptance; the caller lowers it at the end of a burst.
    task automatic send_item(input t_action act, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] val);
        if ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {val, key};
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= cap;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int               pool_size;
        int               eff_cap;
        logic [KEY_W-1:0] key;
        t_action          act;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty miss, extremes, update on hit, fill and evict.
        send_item(ACT_GET, 16'h0000, $urandom);
        send_item(ACT_PUT, 16'h0000, 32'h7FFF_FFFF);
        send_item(ACT_PUT, 16'hFFFF, 32'h8000_0000);
        send_item(ACT_GET, 16'h0000, $urandom);
        send_item(ACT_GET, 16'hFFFF, $urandom);
        send_item(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(ACT_GET, 16'hFFFF, $urandom);
        send_item(ACT_GET, 16'h0001, $urandom);
        for (int k = 1; k <= 14; k++) begin
            send_item(ACT_PUT, KEY_W'(k), VALUE_W'(k * 32'h1111_1111));
        end
        send_item(ACT_PUT, 16'h8000, 32'h0000_0000);
        send_item(ACT_GET, 16'h0000, $urandom);
        drain_results();

        // Capacity of zero, well below the fill count.
        write_capacity(5'd0);
        send_item(ACT_PUT, 16'h5555, 32'h5555_5555);
        send_item(ACT_PUT, 16'hAAAA, 32'hAAAA_AAAA);
        send_item(ACT_GET, 16'h5555, $urandom);
        drain_results();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            if (seg < 3) begin
                src_idle_pct  = 10;
                sink_idle_pct = 75;
            end else if (seg < 6) begin
                src_idle_pct  = 75;
                sink_idle_pct = 10;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            write_capacity(segment_caps[seg]);
            eff_cap = (segment_caps[seg] == 0) ? 1 :
                      ((segment_caps[seg] > 16) ? 16 : int'(segment_caps[seg]));
            pool_size = eff_cap + $urandom_range(1, 6);
            for (int p = 0; p < pool_size; p++) begin
                key_pool[p] = $urandom_range(0, 65535);
            end
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                if (seg == 6 && n == 20) begin
                    hold_off_req = 1'b1;
                end
                key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                : KEY_W'($urandom_range(0, 65535));
                act = $urandom_range(1) ? ACT_PUT : ACT_GET;
                send_item(act, key, pick_value());
            end
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
